// ===== sv/websocket_frame_deframer_unmask_macros.svh =====
// ----------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Shared property shapes for the checker of the deframer.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNMASK_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNMASK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSDU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WSDU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/wsdu_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Types and constants shared by the parser, the queue and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package wsdu_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [6:0] LEN16_CODE  = 7'd126;
   localparam logic [6:0] LEN64_CODE  = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef struct packed {
      logic [7:0] data;
      logic [7:0] key;
      logic [3:0] opcode;
      logic       fin;
      logic       last;
      logic       empty;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== sv/wsdu_parse.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer parser
// Walks the frame header, collects length and masking key, and turns each
// payload byte or empty frame into an item for the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdu_parse
   import wsdu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] in_byte,
   output logic            push,
   output cmd_type         cmd
);

   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_KEY     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   logic [2:0]  phase_ff,   phase_in;
   logic [3:0]  opcode_ff,  opcode_in;
   logic        fin_ff,     fin_in;
   logic        masked_ff,  masked_in;
   logic        long_ff,    long_in;
   logic [3:0]  count_ff,   count_in;
   logic [63:0] remain_ff,  remain_in;
   logic [31:0] key_ff,     key_in;
   logic [1:0]  key_idx_ff, key_idx_in;

   logic [3:0]  count_next;
   logic [63:0] ext_len;
   logic [6:0]  len7;
   logic [7:0]  key_byte;

   assign count_next = count_ff + 4'd1;
   assign ext_len    = {remain_ff[55:0], in_byte};
   assign len7       = in_byte[6:0];

   always_comb begin
      case (key_idx_ff)
         2'd0: key_byte = key_ff[31:24];
         2'd1: key_byte = key_ff[23:16];
         2'd2: key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      opcode_in  = opcode_ff;
      fin_in     = fin_ff;
      masked_in  = masked_ff;
      long_in    = long_ff;
      count_in   = count_ff;
      remain_in  = remain_ff;
      key_in     = key_ff;
      key_idx_in = key_idx_ff;
      push       = 1'b0;
      cmd.data   = 8'd0;
      cmd.key    = 8'd0;
      cmd.opcode = opcode_ff;
      cmd.fin    = fin_ff;
      cmd.last   = 1'b1;
      cmd.empty  = 1'b1;
      if (accept) begin
         case (phase_ff)
            PH_HDR1: begin
               masked_in  = in_byte[7];
               key_in     = 32'd0;
               key_idx_in = 2'd0;
               count_in   = 4'd0;
               if (len7 == LEN64_CODE) begin
                  long_in   = 1'b1;
                  remain_in = 64'd0;
                  phase_in  = PH_EXTLEN;
               end else if (len7 == LEN16_CODE) begin
                  long_in   = 1'b0;
                  remain_in = 64'd0;
                  phase_in  = PH_EXTLEN;
               end else begin
                  remain_in = {57'd0, len7};
                  if (in_byte[7]) begin
                     phase_in = PH_KEY;
                  end else if (len7 == 7'd0) begin
                     phase_in = PH_HDR0;
                     push     = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_EXTLEN: begin
               remain_in = ext_len;
               count_in  = count_next;
               if (count_next >= (long_ff ? EXT64_BYTES : EXT16_BYTES)) begin
                  count_in = 4'd0;
                  if (masked_ff) begin
                     phase_in = PH_KEY;
                  end else if (ext_len == 64'd0) begin
                     phase_in = PH_HDR0;
                     push     = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_KEY: begin
               key_in   = {key_ff[23:0], in_byte};
               count_in = count_next;
               if (count_next >= KEY_BYTES) begin
                  count_in = 4'd0;
                  if (remain_ff == 64'd0) begin
                     phase_in = PH_HDR0;
                     push     = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               key_idx_in = key_idx_ff + 2'd1;
               remain_in  = remain_ff - 64'd1;
               push       = 1'b1;
               cmd.data   = in_byte;
               cmd.key    = key_byte;
               cmd.empty  = 1'b0;
               cmd.last   = (remain_ff == 64'd1);
               if (remain_ff == 64'd1) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               opcode_in = in_byte[3:0];
               fin_in    = in_byte[7];
               phase_in  = PH_HDR1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         opcode_ff  <= 4'd0;
         fin_ff     <= 1'b0;
         masked_ff  <= 1'b0;
         long_ff    <= 1'b0;
         count_ff   <= 4'd0;
         remain_ff  <= 64'd0;
         key_ff     <= 32'd0;
         key_idx_ff <= 2'd0;
      end else begin
         phase_ff   <= phase_in;
         opcode_ff  <= opcode_in;
         fin_ff     <= fin_in;
         masked_ff  <= masked_in;
         long_ff    <= long_in;
         count_ff   <= count_in;
         remain_ff  <= remain_in;
         key_ff     <= key_in;
         key_idx_ff <= key_idx_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/wsdu_queue.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer item queue
// A short first-in first-out queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdu_queue
   import wsdu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire cmd_type    push_cmd,
   input  wire logic       pop,
   output cmd_type         head,
   output queue_status_type status
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff,  count_in;
   logic                do_push;
   logic                do_pop;

   assign status.full      = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;
   assign head             = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/wsdu_emit.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer output stage
// Takes items from the queue, removes the mask and holds the result item
// until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdu_emit
   import wsdu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    head,
   input  wire logic       head_valid,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_payload_byte,
   output logic [3:0]      rsp_frame_opcode,
   output logic            rsp_final_fragment,
   output logic            rsp_last_in_frame,
   output logic            rsp_empty_frame
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic [3:0] opcode_ff;
   logic       fin_ff;
   logic       last_ff;
   logic       empty_ff;

   assign pop = head_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff   <= head.data ^ head.key;
         opcode_ff <= head.opcode;
         fin_ff    <= head.fin;
         last_ff   <= head.last;
         empty_ff  <= head.empty;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_payload_byte   = data_ff;
   assign rsp_frame_opcode   = opcode_ff;
   assign rsp_final_fragment = fin_ff;
   assign rsp_last_in_frame  = last_ff;
   assign rsp_empty_frame    = empty_ff;

endmodule

`default_nettype wire

// ===== sv/websocket_frame_deframer_unmask.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer and unmasker
// Takes a received WebSocket stream one byte per item and returns the
// unmasked payload bytes tagged with opcode, FIN and an end-of-frame mark.
// ----------------------------------------------------------------------------
// The block accepts one byte every clock cycle while req_stall is low. A
// payload byte, or the header byte that completes a zero-length frame, gives
// a result item through the queue and the output register; other header
// bytes give none. The parser pushes results into a two-entry queue ahead of
// the output register, so input is stalled only while that queue is full,
// and it fills only while the output register holds an item that the
// receiver stalls. The parser decrements its 64-bit length once per payload
// byte. No clearing pass is needed after reset.
`default_nettype none

module websocket_frame_deframer_unmask
   import wsdu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_payload_byte,
   output logic [3:0]      rsp_frame_opcode,
   output logic            rsp_final_fragment,
   output logic            rsp_last_in_frame,
   output logic            rsp_empty_frame
);

   logic             accept;
   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head;
   queue_status_type q_status;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   wsdu_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .push    (push),
      .cmd     (push_cmd)
   );

   wsdu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   wsdu_emit u_emit (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .head_valid         (q_status.not_empty),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_final_fragment (rsp_final_fragment),
      .rsp_last_in_frame  (rsp_last_in_frame),
      .rsp_empty_frame    (rsp_empty_frame)
   );

endmodule

`default_nettype wire

// ===== sv/wsdu_checker.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer port checker
// Watches the ports of the deframer over time and flags broken behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

`include "websocket_frame_deframer_unmask_macros.svh"

module wsdu_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_payload_byte,
   input wire logic [3:0] rsp_frame_opcode,
   input wire logic       rsp_final_fragment,
   input wire logic       rsp_last_in_frame,
   input wire logic       rsp_empty_frame
);

   logic        rsp_held;
   logic [14:0] rsp_item;

   assign rsp_held = rsp_valid && rsp_stall;
   assign rsp_item = {rsp_payload_byte, rsp_frame_opcode, rsp_final_fragment,
                      rsp_last_in_frame, rsp_empty_frame};

   `WSDU_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_held, rsp_valid, "Result item dropped.")
   `WSDU_ASSERT_NEXT(a_rsp_item_holds, clock, reset, rsp_held, $stable(rsp_item), "Item changed.")
   `WSDU_ASSERT_SAME(a_empty_is_last, clock, reset, rsp_valid && rsp_empty_frame, rsp_last_in_frame && (rsp_payload_byte == 8'd0), "Bad marker.")
   `WSDU_ASSERT_SAME(a_stall_only_when_held, clock, reset, req_stall, rsp_valid, "Stall with no item.")

endmodule

bind websocket_frame_deframer_unmask wsdu_checker u_checker (.*);

`default_nettype wire

// ===== tb/tb_websocket_frame_deframer_unmask.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer and unmasker testbench
// Drives framed byte streams into the deframer: a few hand-built frames,
// then random frames of every length form with random keys and payloads.
// A scoreboard predicts the unmasked item for each payload byte and empty
// frame and checks the results in order. Sender gaps and receiver stalls vary
// from phase to phase, and one long receiver hold-off comes in the first phase.
// ----------------------------------------------------------------------------

module tb_websocket_frame_deframer_unmask
   import wsdu_pkg::*;
();

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [3:0] frame_opcode;
      logic       final_fragment;
      logic       last_in_frame;
      logic       empty_frame;
   } deframed_item_type;

   typedef enum logic [2:0] {
      AWAIT_HDR0,
      AWAIT_HDR1,
      AWAIT_EXT_LEN,
      AWAIT_KEY,
      AWAIT_PAYLOAD
   } parse_phase_type;

   typedef enum int {LEN_SHORT, LEN_16, LEN_64} len_form_type;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;

   class deframe_scoreboard;
      parse_phase_type   phase;
      logic [3:0]        opcode;
      logic              fin;
      logic              masked;
      logic [3:0]        byte_count;
      logic [3:0]        len_bytes;
      logic [63:0]       bytes_left;
      logic [31:0]       key;
      logic [1:0]        key_pos;
      deframed_item_type expected_q[$];
      int                errors;

      function new();
         phase      = AWAIT_HDR0;
         opcode     = '0;
         fin        = 1'b0;
         masked     = 1'b0;
         byte_count = '0;
         len_bytes  = '0;
         bytes_left = '0;
         key        = '0;
         key_pos    = '0;
         errors     = 0;
      endfunction

      function void expect_item(logic [7:0] data, logic last, logic empty);
         expected_q.push_back({data, opcode, fin, last, empty});
      endfunction

      function void header_done();
         if (bytes_left == 0) begin
            phase = AWAIT_HDR0;
            expect_item(8'h00, 1'b1, 1'b1);
         end else begin
            phase = AWAIT_PAYLOAD;
         end
      endfunction

      function void length_done();
         byte_count = '0;
         if (masked) begin
            phase = AWAIT_KEY;
         end else begin
            header_done();
         end
      endfunction

      function void note_byte(logic [7:0] b);
         logic [7:0] k;
         case (phase)
            AWAIT_HDR1: begin
               masked     = b[7];
               key        = '0;
               key_pos    = '0;
               byte_count = '0;
               bytes_left = '0;
               if (b[6:0] == LEN64_CODE) begin
                  len_bytes = EXT64_BYTES;
                  phase     = AWAIT_EXT_LEN;
               end else if (b[6:0] == LEN16_CODE) begin
                  len_bytes = EXT16_BYTES;
                  phase     = AWAIT_EXT_LEN;
               end else begin
                  bytes_left = {57'd0, b[6:0]};
                  length_done();
               end
            end
            AWAIT_EXT_LEN: begin
               bytes_left = {bytes_left[55:0], b};
               byte_count = byte_count + 4'd1;
               if (byte_count >= len_bytes) length_done();
            end
            AWAIT_KEY: begin
               key        = {key[23:0], b};
               byte_count = byte_count + 4'd1;
               if (byte_count >= KEY_BYTES) begin
                  byte_count = '0;
                  header_done();
               end
            end
            AWAIT_PAYLOAD: begin
               k          = key[8 * (3 - int'(key_pos)) +: 8];
               key_pos    = key_pos + 2'd1;
               bytes_left = bytes_left - 64'd1;
               expect_item(b ^ k, bytes_left == 0, 1'b0);
               if (bytes_left == 0) phase = AWAIT_HDR0;
            end
            default: begin
               opcode = b[3:0];
               fin    = b[7];
               phase  = AWAIT_HDR1;
            end
         endcase
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(deframed_item_type got);
         deframed_item_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = expected_q.pop_front();
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("frame_opcode", want.frame_opcode, got.frame_opcode);
            compare_field("final_fragment", want.final_fragment, got.final_fragment);
            compare_field("last_in_frame", want.last_in_frame, got.last_in_frame);
            compare_field("empty_frame", want.empty_frame, got.empty_frame);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic [3:0] rsp_frame_opcode;
   logic       rsp_final_fragment;
   logic       rsp_last_in_frame;
   logic       rsp_empty_frame;

   deframe_scoreboard book = new();

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int sent_bytes    = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   websocket_frame_deframer_unmask DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_final_fragment (rsp_final_fragment),
      .rsp_last_in_frame  (rsp_last_in_frame),
      .rsp_empty_frame    (rsp_empty_frame)
   );

   always #10 clock = ~clock;

   // The long hold-off is counted here, so that the sender carries on meanwhile.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            book.check_result({rsp_payload_byte, rsp_frame_opcode, rsp_final_fragment,
                               rsp_last_in_frame, rsp_empty_frame});
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_served + 1;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("websocket_frame_deframer_unmask regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_byte(b);
      sent_bytes++;
   endtask

   task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] opcode,
                             input logic masked, input len_form_type form,
                             input logic [63:0] length, input logic [31:0] mask_bits,
                             input int payload_count);
      send_byte({fin, rsv, opcode});
      case (form)
         LEN_16: begin
            send_byte({masked, LEN16_CODE});
            send_byte(length[15:8]);
            send_byte(length[7:0]);
         end
         LEN_64: begin
            send_byte({masked, LEN64_CODE});
            for (int i = 7; i >= 0; i--) send_byte(length[8 * i +: 8]);
         end
         default: send_byte({masked, length[6:0]});
      endcase
      if (masked) begin
         for (int i = 3; i >= 0; i--) send_byte(mask_bits[8 * i +: 8]);
      end
      for (int i = 0; i < payload_count; i++) send_byte(8'($urandom));
   endtask

   task automatic send_random_frame();
      int           pick;
      len_form_type form;
      logic [63:0]  length;
      pick = $urandom_range(99);
      if (pick < 75) begin
         form   = LEN_SHORT;
         length = 64'(($urandom_range(3) == 0) ? $urandom_range(125) : $urandom_range(8));
      end else if (pick < 88) begin
         form   = LEN_16;
         length = 64'(($urandom_range(3) == 0) ? $urandom_range(4)
                                                : $urandom_range(126, 290));
      end else begin
         form   = LEN_64;
         length = 64'($urandom_range(12));
      end
      send_frame(1'($urandom), 3'($urandom), 4'($urandom), ($urandom_range(9) < 7),
                 form, length, $urandom, int'(length));
   endtask

   task automatic run_phase(input int idle_pct, input int hold_pct, input int byte_goal);
      send_idle_pct = idle_pct;
      stall_pct     = hold_pct;
      while (sent_bytes < byte_goal) send_random_frame();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty ping, then an empty masked pong whose marker comes with the last key byte.
      send_frame(1'b1, 3'b000, 4'h9, 1'b0, LEN_SHORT, 64'd0, 32'h0, 0);
      send_frame(1'b1, 3'b000, 4'hA, 1'b1, LEN_SHORT, 64'd0, 32'h0102_0304, 0);
      // Reserved bits set and a reserved opcode, with an all-ones key byte.
      send_frame(1'b1, 3'b111, 4'hF, 1'b1, LEN_SHORT, 64'd2, 32'hFF00_AA55, 2);
      // A non-minimal 16-bit length of zero on an unmasked continuation frame.
      send_frame(1'b0, 3'b000, 4'h0, 1'b0, LEN_16, 64'd0, 32'h0, 0);

      hold_requests = hold_requests + 1;
      run_phase(0, 0, 450);
      run_phase(70, 0, 850);
      run_phase(0, 70, 1250);
      run_phase(11, 11, 1650);

      // A 64-bit length of all ones never ends, so this frame closes the stream.
      send_frame(1'b1, 3'($urandom), 4'($urandom), 1'b1, LEN_64, '1, $urandom, 60);
      req_valid <= 1'b0;

      while (book.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (book.pending() != 0) begin
         $display("%0t: %0d expected items never arrived", $time, book.pending());
         book.errors++;
      end
      if (book.errors == 0) begin
         $display("websocket_frame_deframer_unmask regression: pass");
      end else begin
         $display("websocket_frame_deframer_unmask regression: fail");
      end
      $finish;
   end

endmodule
